@@ design/fat_directory_entry_decoder_macros.svh @@
// assertion macros used by the directory entry decoder
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef FAT_DIRECTORY_ENTRY_DECODER_MACROS_SVH
`define FAT_DIRECTORY_ENTRY_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FDD_ASSERT(lbl, prop, msg)
`define FDD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/fdd_pkg.sv @@
// shared types, codes and constants of the directory entry decoder
// no dependencies
package fdd_pkg;

  localparam int unsigned CHARS_PER_CHUNK = 8;
  localparam int unsigned LFN_CHARS       = 13;
  localparam int unsigned MAX_CHUNKS      = 16;
  localparam int unsigned LANE_ROW_W      = 5;

  localparam logic [7:0] BYTE_END     = 8'h00;
  localparam logic [7:0] BYTE_DELETED = 8'hE5;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam int unsigned ATTR_VOLUME_BIT = 3;
  localparam int unsigned ATTR_DIR_BIT    = 4;
  localparam int unsigned LFN_FIRST_BIT   = 6;
  localparam int unsigned CASE_BASE_BIT   = 3;
  localparam int unsigned CASE_EXT_BIT    = 4;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;

  localparam logic KIND_NAME = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic                  en;
    logic [LANE_ROW_W-1:0] row;
    logic [7:0]            data;
  } fdd_lane_wr_t;

  // byte offset of the low half of each long-name character
  function automatic logic [4:0] lfn_pos(input logic [3:0] j);
    logic [4:0] p;
    case (j)
      4'd0:    p = 5'd1;
      4'd1:    p = 5'd3;
      4'd2:    p = 5'd5;
      4'd3:    p = 5'd7;
      4'd4:    p = 5'd9;
      4'd5:    p = 5'd14;
      4'd6:    p = 5'd16;
      4'd7:    p = 5'd18;
      4'd8:    p = 5'd20;
      4'd9:    p = 5'd22;
      4'd10:   p = 5'd24;
      4'd11:   p = 5'd28;
      4'd12:   p = 5'd30;
      default: p = 5'd1;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

endpackage

@@ design/fdd_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module fdd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
endmodule

@@ design/fdd_lane.sv @@
// one byte lane of the long-name store: ram bank plus per-row written flags
// depends on fdd_pkg and fdd_ram
module fdd_lane #(
  parameter int unsigned ROWS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fdd_pkg::fdd_lane_wr_t             wr_i,
  input  logic                              rd_en_i,
  input  logic [fdd_pkg::LANE_ROW_W-1:0]    rd_row_i,
  output logic [7:0]                        rd_byte_o
);
  import fdd_pkg::*;

  localparam int unsigned RW = $clog2(ROWS);

  logic [ROWS-1:0] valid_q;
  logic            rd_valid_q;
  logic [7:0]      ram_byte;

  fdd_ram #(.WIDTH(8), .DEPTH(ROWS)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_i.en),
    .wr_addr_i (wr_i.row[RW-1:0]),
    .wr_data_i (wr_i.data),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (rd_row_i[RW-1:0]),
    .rd_data_o (ram_byte)
  );

  // never-written entries read as zero, the reset content of the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) valid_q[wr_i.row[RW-1:0]] <= 1'b1;
      if (rd_en_i) rd_valid_q <= valid_q[rd_row_i[RW-1:0]];
    end
  end

  assign rd_byte_o = rd_valid_q ? ram_byte : 8'h00;
endmodule

@@ design/fdd_short.sv @@
// 8.3 short name former: trims spaces, applies case flags, inserts the dot before a non-empty extension
// depends on fdd_pkg
module fdd_short (
  input  logic [103:0] entry_i,
  output logic [95:0]  name_o,
  output logic [3:0]   len_o
);
  import fdd_pkg::*;

  logic [3:0] base_end;
  logic [3:0] ext_end;
  logic [3:0] idx;
  logic       low_base;
  logic       low_ext;

  assign low_base = entry_i[96 + CASE_BASE_BIT];
  assign low_ext  = entry_i[96 + CASE_EXT_BIT];

  always_comb begin
    base_end = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (base_end == 4'(i + 1) && entry_i[8*i +: 8] == CHAR_SPACE) base_end = 4'(i);
    end
    ext_end = 4'd11;
    for (int i = 10; i >= 8; i--) begin
      if (ext_end == 4'(i + 1) && entry_i[8*i +: 8] == CHAR_SPACE) ext_end = 4'(i);
    end
  end

  always_comb begin
    name_o = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < base_end) name_o[8*i +: 8] = to_lower(entry_i[8*i +: 8], low_base);
    end
    idx = base_end;
    if (ext_end > 4'd8) begin
      name_o[8*idx +: 8] = CHAR_DOT;
      for (int e = 0; e < 3; e++) begin
        if (4'(8 + e) < ext_end) begin
          name_o[8*(idx + 4'(1 + e)) +: 8] = to_lower(entry_i[8*(8 + e) +: 8], low_ext);
        end
      end
    end
    len_o = (ext_end > 4'd8) ? base_end + 4'd1 + (ext_end - 4'd8) : base_end;
  end
endmodule

@@ design/fat_directory_entry_decoder.sv @@
// FAT directory entry decoder. One 32-byte entry is taken per input beat once
// the block is idle. An end marker gives one result beat; a long-name part
// writes its 13 characters into eight byte-lane banks of the name store, in
// order: accept, decode with the first lane write, then the second lane
// write; a skipped entry is accepted, decoded and dropped. A regular entry is
// accepted and decoded, then each name chunk of 8 characters, up to 16 chunks,
// is read (long names through the registered lane-bank read) and emitted;
// skipping drops dot entries. Output stalls hold the emit. The store powers up
// empty through per-row written flags in each lane, so no clearing pass follows
// reset. Depends on fdd_pkg, fdd_lane, fdd_short and the assertion macro header.
`include "fat_directory_entry_decoder_macros.svh"
module fat_directory_entry_decoder #(
  parameter int unsigned NAME_MAX_CHARS = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        skip_dot_entries_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] entry_bytes_0_7_i,
  input  logic [63:0] entry_bytes_8_15_i,
  input  logic [63:0] entry_bytes_16_23_i,
  input  logic [63:0] entry_bytes_24_31_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [63:0] name_chars_o,
  output logic [3:0]  char_count_o,
  output logic        last_o,
  output logic        from_long_name_o,
  output logic [7:0]  attributes_o,
  output logic        is_directory_o,
  output logic [31:0] first_cluster_o,
  output logic [31:0] file_size_o
);
  import fdd_pkg::*;

  localparam int unsigned ROWS = (NAME_MAX_CHARS + CHARS_PER_CHUNK - 1) / CHARS_PER_CHUNK;
  localparam int unsigned LW   = $clog2(NAME_MAX_CHARS + 1);
  localparam int unsigned NLW  = (LW > 7) ? LW : 7;
  localparam int unsigned CMW  = NLW - 3;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_LFN_HI, S_END, S_RD, S_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic            skip_q;
  logic            have_q, have_d;
  logic [LW-1:0]   len_q, len_d;
  logic            from_long_q, from_long_d;
  logic [NLW-1:0]  nlen_q, nlen_d;
  logic [3:0]      chunks_m1_q, chunks_m1_d;
  logic [3:0]      k_q, k_d;
  logic            out_valid_q, out_valid_d;
  logic            load_name, load_end, take_in;
  logic [255:0]    entry_q;

  logic [7:0]      b0, attr;
  logic [4:0]      seq;
  logic [8:0]      pos0;
  logic [15:0]     lfn_ch [LFN_CHARS];
  logic            ch_ok  [LFN_CHARS];
  logic [8:0]      new_max;
  logic [LW-1:0]   len_base;
  fdd_lane_wr_t    lane_wr_g [2][CHARS_PER_CHUNK];
  fdd_lane_wr_t    lane_wr   [CHARS_PER_CHUNK];
  logic            rd_en;
  logic [7:0]      lane_byte [CHARS_PER_CHUNK];
  logic [95:0]     sname;
  logic [3:0]      snlen;
  logic [NLW-1:0]  nm1, rem;
  logic [CMW-1:0]  cm1_raw;
  logic [3:0]      cnt;
  logic [63:0]     raw_chunk, chunk;
  logic            dot_name;
  logic            out_free;

  assign b0   = entry_q[7:0];
  assign attr = entry_q[95:88];
  assign seq  = b0[4:0];
  assign pos0 = 9'((9'(seq) - 9'd1) * 9'd13);

  fdd_short u_short (
    .entry_i (entry_q[103:0]),
    .name_o  (sname),
    .len_o   (snlen)
  );

  // long-name characters and the furthest position written by this part
  always_comb begin
    new_max = '0;
    for (int i = 0; i < LFN_CHARS; i++) begin
      lfn_ch[i] = {entry_q[8*(int'(lfn_pos(4'(i))) + 1) +: 8],
                   entry_q[8*int'(lfn_pos(4'(i))) +: 8]};
      ch_ok[i]  = (lfn_ch[i] != 16'h0000) && (lfn_ch[i] != 16'hFFFF) &&
                  (pos0 + 9'(i) < 9'(NAME_MAX_CHARS));
      if (ch_ok[i]) new_max = pos0 + 9'(i + 1);
    end
  end

  // lane b takes the character whose position falls in bank b, one per group
  always_comb begin
    logic [2:0] off;
    logic [3:0] j;
    logic [8:0] pos;
    for (int g = 0; g < 2; g++) begin
      for (int b = 0; b < CHARS_PER_CHUNK; b++) begin
        off = 3'(b) - pos0[2:0];
        j   = {g[0], off};
        pos = pos0 + 9'(j);
        lane_wr_g[g][b].en   = (j < 4'(LFN_CHARS)) && ch_ok[j];
        lane_wr_g[g][b].row  = pos[LANE_ROW_W+2:3];
        lane_wr_g[g][b].data = (lfn_ch[j] < 16'h0080) ? lfn_ch[j][7:0] : CHAR_QMARK;
      end
    end
  end

  for (genvar b = 0; b < CHARS_PER_CHUNK; b++) begin : g_lane
    fdd_lane #(.ROWS(ROWS)) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (lane_wr[b]),
      .rd_en_i   (rd_en),
      .rd_row_i  (LANE_ROW_W'(k_q)),
      .rd_byte_o (lane_byte[b])
    );
  end

  // merge: pick the chunk source, cut it to the valid count
  always_comb begin
    for (int b = 0; b < CHARS_PER_CHUNK; b++) raw_chunk[8*b +: 8] = lane_byte[b];
    if (!from_long_q) raw_chunk = (k_q == 4'd0) ? sname[63:0] : {32'h0, sname[95:64]};
    rem = nlen_q - {{(NLW-7){1'b0}}, k_q, 3'b000};
    cnt = (rem >= NLW'(CHARS_PER_CHUNK)) ? 4'(CHARS_PER_CHUNK) : rem[3:0];
    for (int b = 0; b < CHARS_PER_CHUNK; b++) begin
      chunk[8*b +: 8] = (4'(b) < cnt) ? raw_chunk[8*b +: 8] : 8'h00;
    end
    dot_name = (nlen_q == '0) ||
               (nlen_q == NLW'(1) && raw_chunk[7:0] == CHAR_DOT) ||
               (nlen_q == NLW'(2) && raw_chunk[7:0] == CHAR_DOT &&
                raw_chunk[15:8] == CHAR_DOT);
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign len_base    = entry_q[LFN_FIRST_BIT] ? '0 : len_q;

  always_comb begin
    state_d     = state_q;
    have_d      = have_q;
    len_d       = len_q;
    from_long_d = from_long_q;
    nlen_d      = nlen_q;
    chunks_m1_d = chunks_m1_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    load_name   = 1'b0;
    load_end    = 1'b0;
    take_in     = 1'b0;
    rd_en       = 1'b0;
    nm1         = '0;
    cm1_raw     = '0;
    for (int b = 0; b < CHARS_PER_CHUNK; b++) lane_wr[b] = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          take_in = 1'b1;
          if (restart_i) begin
            have_d = 1'b0;
            len_d  = '0;
          end
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (b0 == BYTE_END) begin
          state_d = S_END;
        end else if (attr == ATTR_LFN) begin
          if (seq == 5'd0) begin
            have_d  = 1'b0;
            len_d   = '0;
            state_d = S_IDLE;
          end else begin
            for (int b = 0; b < CHARS_PER_CHUNK; b++) lane_wr[b] = lane_wr_g[0][b];
            have_d  = 1'b1;
            len_d   = (new_max > 9'(len_base)) ? LW'(new_max) : len_base;
            state_d = S_LFN_HI;
          end
        end else if (b0 == BYTE_DELETED || attr[ATTR_VOLUME_BIT]) begin
          have_d  = 1'b0;
          len_d   = '0;
          state_d = S_IDLE;
        end else begin
          from_long_d = have_q;
          nlen_d      = have_q ? NLW'(len_q) : NLW'(snlen);
          nm1         = nlen_d - NLW'(1);
          cm1_raw     = nm1[NLW-1:3];
          if (nlen_d == '0)                      chunks_m1_d = 4'd0;
          else if (cm1_raw > CMW'(MAX_CHUNKS - 1)) chunks_m1_d = 4'(MAX_CHUNKS - 1);
          else                                   chunks_m1_d = cm1_raw[3:0];
          k_d     = 4'd0;
          have_d  = 1'b0;
          len_d   = '0;
          state_d = S_RD;
        end
      end
      S_LFN_HI: begin
        for (int b = 0; b < CHARS_PER_CHUNK; b++) lane_wr[b] = lane_wr_g[1][b];
        state_d = S_IDLE;
      end
      S_END: begin
        if (out_free) begin
          load_end    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (k_q == 4'd0 && skip_q && dot_name) begin
            state_d = S_IDLE;
          end else begin
            load_name   = 1'b1;
            out_valid_d = 1'b1;
            if (k_q == chunks_m1_q) begin
              state_d = S_IDLE;
            end else begin
              k_d     = k_q + 4'd1;
              state_d = S_RD;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      skip_q      <= 1'b0;
      have_q      <= 1'b0;
      len_q       <= '0;
      from_long_q <= 1'b0;
      nlen_q      <= '0;
      chunks_m1_q <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i) skip_q <= skip_dot_entries_i;
      have_q      <= have_d;
      len_q       <= len_d;
      from_long_q <= from_long_d;
      nlen_q      <= nlen_d;
      chunks_m1_q <= chunks_m1_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      entry_q <= {entry_bytes_24_31_i, entry_bytes_16_23_i,
                  entry_bytes_8_15_i, entry_bytes_0_7_i};
    end
    if (load_end) begin
      result_kind_o    <= KIND_END;
      name_chars_o     <= '0;
      char_count_o     <= '0;
      last_o           <= 1'b1;
      from_long_name_o <= 1'b0;
      attributes_o     <= '0;
      is_directory_o   <= 1'b0;
      first_cluster_o  <= '0;
      file_size_o      <= '0;
    end else if (load_name) begin
      result_kind_o    <= KIND_NAME;
      name_chars_o     <= chunk;
      char_count_o     <= cnt;
      last_o           <= (k_q == chunks_m1_q);
      from_long_name_o <= from_long_q;
      attributes_o     <= attr;
      is_directory_o   <= attr[ATTR_DIR_BIT];
      first_cluster_o  <= {entry_q[175:160], entry_q[223:208]};
      file_size_o      <= entry_q[255:224];
    end
  end

  assign out_valid_o = out_valid_q;

  `FDD_ASSERT(a_end_is_last, (out_valid_o && result_kind_o == KIND_END) |-> last_o, "end beat not last")
  `FDD_ASSERT(a_end_empty, (out_valid_o && result_kind_o == KIND_END) |-> (name_chars_o == '0 && char_count_o == 4'd0), "end beat carries data")
  `FDD_ASSERT(a_count_max, (out_valid_o && result_kind_o == KIND_NAME) |-> (char_count_o <= 4'(CHARS_PER_CHUNK)), "chunk count too large")
  `FDD_ASSERT(a_full_mid, (out_valid_o && result_kind_o == KIND_NAME && !last_o) |-> (char_count_o == 4'(CHARS_PER_CHUNK)), "non-final chunk not full")
  `FDD_ASSERT_ALWAYS(a_no_write_idle, (state_q == S_IDLE) |-> !lane_wr[0].en, "lane write while idle")
endmodule
